/* hw/rtl/tswr_pkg.sv */
// Shared types and constants for the TCP sender window and retransmit engine.
package tswr_pkg;

  localparam int unsigned QueueDepthDef = 64;
  localparam int unsigned MaxBurstDef   = 64;

  localparam logic [31:0] InitSeqRst     = 32'd0;
  localparam logic [15:0] InitTimeoutRst = 16'd1000;
  localparam logic [11:0] MaxPayloadRst  = 12'd1000;

  localparam logic [1:0] CfgInitSeq     = 2'd0;
  localparam logic [1:0] CfgInitTimeout = 2'd1;
  localparam logic [1:0] CfgMaxPayload  = 2'd2;

  typedef enum logic [1:0] {
    OP_FILL  = 2'd0,
    OP_ACK   = 2'd1,
    OP_TICK  = 2'd2,
    OP_EMPTY = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    KIND_STATUS = 2'd0,
    KIND_NEW    = 2'd1,
    KIND_RETX   = 2'd2,
    KIND_EMPTY  = 2'd3
  } kind_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ACK_CHK,
    ST_POP_RD,
    ST_POP_CHK,
    ST_FILL_CHK,
    ST_FILL_LOOP,
    ST_ACK_TAIL,
    ST_TICK_DO,
    ST_DONE,
    ST_EMIT_RD,
    ST_EMIT_LD,
    ST_OUT_WAIT
  } state_e;

  // one outstanding segment
  typedef struct packed {
    logic [63:0] start;
    logic [11:0] pl;
    logic        syn;
    logic        fin;
  } entry_t;

endpackage

/* hw/rtl/tswr_queue.sv */
// Outstanding segment store: one write port, one registered read port.
module tswr_queue #(
  parameter int unsigned DEPTH = tswr_pkg::QueueDepthDef,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  tswr_pkg::entry_t wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output tswr_pkg::entry_t rdata_o
);
  import tswr_pkg::*;

  entry_t mem [DEPTH];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/tcp_sender_window_retransmit.sv */
// TCP sender sequence engine: segmentation, outstanding queue, retransmit timer.
// Per input: an empty-segment request goes straight to output; a tick that fires passes
// TICK_DO, else DONE; an ignored ack passes ACK_CHK, then DONE. A fill passes FILL_CHK and
// FILL_LOOP, queueing one new segment per cycle; no loop for SYN or lone FIN. An ack passes
// ACK_CHK, POP_RD/POP_CHK per entry, the fill path if any entry popped, then ACK_TAIL, DONE.
// Results are read via EMIT_RD, EMIT_LD; next input is taken after the last result transfer.
// Reset (async, active low) clears all control state; queue contents stay undefined.
module tcp_sender_window_retransmit #(
  parameter int unsigned QUEUE_DEPTH = tswr_pkg::QueueDepthDef,
  parameter int unsigned MAX_BURST   = tswr_pkg::MaxBurstDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // ack_number[31:0], peer_window[47:32], elapsed_ms[63:48],
  // buffered_bytes[79:64], stream_ended[80], zero fill
  input  logic [87:0] s_axis_tdata,
  // op[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // seqno[31:0], payload_len[43:32], syn[44], fin[45], in_flight[62:46],
  // retx_count[70:63], zero fill
  output logic [71:0] m_axis_tdata,
  // kind[1:0]
  output logic [1:0]  m_axis_tuser,
  output logic        m_axis_tlast
);
  import tswr_pkg::*;

  localparam int unsigned QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned NW = $clog2(MAX_BURST + 1);

  state_e state_q, state_d;

  logic [31:0] iseq_q, iseq_d;
  logic [15:0] ito_q, ito_d;
  logic [11:0] mpay_q, mpay_d;

  logic        syn_sent_q, syn_sent_d, fin_sent_q, fin_sent_d;
  logic [63:0] next_q, next_d, acked_q, acked_d;
  logic [15:0] win_q, win_d;
  logic [16:0] unack_q, unack_d;
  logic        ton_q, ton_d;
  logic [31:0] tel_q, tel_d, tout_q, tout_d;
  logic [7:0]  retx_q, retx_d;
  logic [QW-1:0] head_q, head_d;
  logic [CW-1:0] count_q, count_d;

  // per-event work registers
  logic [15:0] wnd_q, wnd_d, buf_q, buf_d;
  logic        ended_q, ended_d, from_ack_q, from_ack_d, popped_q, popped_d;
  logic [63:0] aabs_q, aabs_d;
  logic signed [18:0] room_q, room_d;
  logic [NW-1:0] nres_q, nres_d, k_q, k_d;
  logic [QW-1:0] first_q, first_d, eslot_q, eslot_d;

  logic        ov_q, ov_d, olast_q, olast_d, osyn_q, osyn_d, ofin_q, ofin_d;
  logic [1:0]  okind_q, okind_d;
  logic [31:0] oseq_q, oseq_d;
  logic [11:0] opl_q, opl_d;
  logic [16:0] oinf_q, oinf_d;
  logic [7:0]  oretx_q, oretx_d;

  // queue port
  logic    we;
  entry_t  wdata, rdata;
  logic [QW-1:0] raddr;

  // shared combinational terms
  logic [QW+1:0] tail_sum;
  logic [QW-1:0] tail, head_inc, eslot_inc;
  logic          can_send, s_fire, m_fire;
  logic [63:0]   fwd_abs;
  logic [64:0]   fwd_sum;
  logic [31:0]   ack_d32;
  logic [63:0]   ack_unwrapped;
  logic [16:0]   win_eff, diff;
  logic signed [18:0] room_now;
  logic [11:0]   mp;
  logic [15:0]   pl_a, pl_b;
  logic [11:0]   pl_loop;
  logic [15:0]   buf_rem;
  logic          fin_ride, loop_go;
  logic [12:0]   rd_len;
  logic [63:0]   rd_end;
  logic          pop_ok;
  logic [32:0]   tel_sum;
  logic [31:0]   tel_sat;
  logic          tick_fire;
  logic [NW-1:0] k_inc;

  tswr_queue #(.DEPTH(QUEUE_DEPTH), .AW(QW)) u_queue (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (tail),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign s_fire = s_axis_tvalid && s_axis_tready;
  assign m_fire = m_axis_tvalid && m_axis_tready;

  assign tail_sum = (QW + 2)'(head_q) + (QW + 2)'(count_q);
  assign tail = (tail_sum >= (QW + 2)'(QUEUE_DEPTH)) ?
                QW'(tail_sum - (QW + 2)'(QUEUE_DEPTH)) : QW'(tail_sum);
  assign head_inc  = (head_q == QW'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
  assign eslot_inc = (eslot_q == QW'(QUEUE_DEPTH - 1)) ? '0 : eslot_q + 1'b1;
  assign can_send  = (nres_q < NW'(MAX_BURST)) && (count_q < CW'(QUEUE_DEPTH));
  assign k_inc     = k_q + 1'b1;

  // ack unwrap: nearest absolute value to next_q
  assign ack_d32 = s_axis_tdata[31:0] - iseq_q - next_q[31:0];
  assign fwd_sum = {1'b0, next_q} + {33'd0, ack_d32};
  assign fwd_abs = fwd_sum[63:0];
  assign ack_unwrapped = (ack_d32[31] && (fwd_sum[64:32] != 33'd0)) ?
                         (fwd_abs - 64'h1_0000_0000) : fwd_abs;

  assign win_eff  = (win_q == 16'd0) ? 17'd1 : {1'b0, win_q};
  assign diff     = 17'(next_q - acked_q);
  assign room_now = $signed({2'b00, win_eff}) - $signed({2'b00, diff});

  assign mp   = (mpay_q == 12'd0) ? 12'd1 : mpay_q;
  assign pl_a = (buf_q < {4'd0, mp}) ? buf_q : {4'd0, mp};
  assign pl_b = ({3'd0, pl_a} > room_q[18:0]) ? 16'(room_q) : pl_a;
  assign pl_loop  = 12'(pl_b);
  assign buf_rem  = buf_q - pl_b;
  assign fin_ride = ended_q && (buf_rem == 16'd0) && (room_q > $signed({3'd0, pl_b}));
  assign loop_go  = (buf_q != 16'd0) && (room_q > 19'sd0) && can_send;

  assign rd_len = 13'(rdata.pl) + 13'(rdata.syn) + 13'(rdata.fin);
  assign rd_end = rdata.start + 64'(rd_len);
  assign pop_ok = (count_q != '0) && (rd_end <= aabs_q);

  assign tel_sum   = {1'b0, tel_q} + {17'd0, s_axis_tdata[63:48]};
  assign tel_sat   = tel_sum[32] ? 32'hFFFF_FFFF : tel_sum[31:0];
  assign tick_fire = ton_q && (tel_sat >= tout_q) && (count_q != '0);

  assign raddr = (state_q == ST_EMIT_RD) ? eslot_q : head_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_fire) begin
          unique case (op_e'(s_axis_tuser))
            OP_FILL:  state_d = ST_FILL_CHK;
            OP_ACK:   state_d = ST_ACK_CHK;
            OP_TICK:  state_d = tick_fire ? ST_TICK_DO : ST_DONE;
            OP_EMPTY: state_d = ST_OUT_WAIT;
            default:  state_d = ST_DONE;
          endcase
        end
      end
      ST_ACK_CHK: begin
        if (aabs_q > next_q || aabs_q <= acked_q) begin
          state_d = ST_DONE;
        end else begin
          state_d = ST_POP_RD;
        end
      end
      ST_POP_RD:  state_d = ST_POP_CHK;
      ST_POP_CHK: begin
        if (pop_ok) begin
          state_d = ST_POP_RD;
        end else if (popped_q) begin
          state_d = ST_FILL_CHK;
        end else begin
          state_d = ST_ACK_TAIL;
        end
      end
      ST_FILL_CHK: begin
        if (syn_sent_q && !(count_q != '0 && rdata.syn) && !fin_sent_q &&
            !(ended_q && buf_q == 16'd0)) begin
          state_d = ST_FILL_LOOP;
        end else begin
          state_d = from_ack_q ? ST_ACK_TAIL : ST_DONE;
        end
      end
      ST_FILL_LOOP: begin
        if (!loop_go || fin_ride) begin
          state_d = from_ack_q ? ST_ACK_TAIL : ST_DONE;
        end
      end
      ST_ACK_TAIL: state_d = ST_DONE;
      ST_TICK_DO:  state_d = ST_OUT_WAIT;
      ST_DONE:     state_d = (nres_q == '0) ? ST_OUT_WAIT : ST_EMIT_RD;
      ST_EMIT_RD:  state_d = ST_EMIT_LD;
      ST_EMIT_LD:  state_d = ST_OUT_WAIT;
      ST_OUT_WAIT: begin
        if (m_fire) begin
          state_d = (k_inc < nres_q) ? ST_EMIT_RD : ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    iseq_d = iseq_q; ito_d = ito_q; mpay_d = mpay_q;
    syn_sent_d = syn_sent_q; fin_sent_d = fin_sent_q;
    next_d = next_q; acked_d = acked_q; win_d = win_q; unack_d = unack_q;
    ton_d = ton_q; tel_d = tel_q; tout_d = tout_q; retx_d = retx_q;
    head_d = head_q; count_d = count_q;
    wnd_d = wnd_q; buf_d = buf_q; ended_d = ended_q;
    from_ack_d = from_ack_q; popped_d = popped_q; aabs_d = aabs_q;
    room_d = room_q; nres_d = nres_q; k_d = k_q;
    first_d = first_q; eslot_d = eslot_q;
    ov_d = ov_q; olast_d = olast_q; osyn_d = osyn_q; ofin_d = ofin_q;
    okind_d = okind_q; oseq_d = oseq_q; opl_d = opl_q;
    oinf_d = oinf_q; oretx_d = oretx_q;
    we = 1'b0;
    wdata = '{start: next_q, pl: 12'd0, syn: 1'b0, fin: 1'b0};

    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgInitSeq:     iseq_d = cfg_data_i;
        CfgInitTimeout: begin
          ito_d  = cfg_data_i[15:0];
          tout_d = {16'd0, cfg_data_i[15:0]};
        end
        CfgMaxPayload:  mpay_d = cfg_data_i[11:0];
        default: ;
      endcase
    end

    unique case (state_q)
      ST_IDLE: begin
        if (s_fire) begin
          wnd_d = s_axis_tdata[47:32];
          buf_d = s_axis_tdata[79:64];
          ended_d = s_axis_tdata[80];
          aabs_d = ack_unwrapped;
          from_ack_d = (op_e'(s_axis_tuser) == OP_ACK);
          popped_d = 1'b0;
          nres_d = '0;
          k_d = '0;
          if (op_e'(s_axis_tuser) == OP_TICK && ton_q) begin
            tel_d = tel_sat;
          end
          if (op_e'(s_axis_tuser) == OP_EMPTY) begin
            ov_d = 1'b1; okind_d = KIND_EMPTY; oseq_d = 32'(next_q + 64'(iseq_q));
            opl_d = '0; osyn_d = 1'b0; ofin_d = 1'b0; olast_d = 1'b1;
            oinf_d = unack_q; oretx_d = retx_q;
          end
        end
      end
      ST_ACK_CHK: begin
        if (aabs_q <= next_q) begin
          win_d = wnd_q;
          if (aabs_q > acked_q) begin
            acked_d = aabs_q;
          end
        end
      end
      ST_POP_CHK: begin
        if (pop_ok) begin
          head_d = head_inc;
          count_d = count_q - 1'b1;
          unack_d = unack_q - 17'(rd_len);
          popped_d = 1'b1;
        end
      end
      ST_FILL_CHK: begin
        if (!syn_sent_q) begin
          if (can_send) begin
            syn_sent_d = 1'b1;
            we = 1'b1;
            wdata.syn = 1'b1;
          end
        end else if (!(count_q != '0 && rdata.syn) && !fin_sent_q) begin
          room_d = room_now;
          if (ended_q && buf_q == 16'd0 && room_now > 19'sd0 && can_send) begin
            fin_sent_d = 1'b1;
            we = 1'b1;
            wdata.fin = 1'b1;
          end
        end
      end
      ST_FILL_LOOP: begin
        if (loop_go) begin
          we = 1'b1;
          wdata.pl = pl_loop;
          wdata.fin = fin_ride;
          buf_d = buf_rem;
          room_d = room_q - $signed({3'd0, pl_b}) - $signed(19'(fin_ride));
          if (fin_ride) begin
            fin_sent_d = 1'b1;
          end
        end
      end
      ST_ACK_TAIL: begin
        retx_d = '0;
        tout_d = {16'd0, ito_q};
        if (count_q == '0) begin
          ton_d = 1'b0;
        end else begin
          ton_d = 1'b1;
          tel_d = '0;
        end
      end
      ST_TICK_DO: begin
        if (win_q != 16'd0 || rdata.syn) begin
          if (retx_q != 8'hFF) begin
            retx_d = retx_q + 1'b1;
          end
          tout_d = tout_q[31] ? 32'hFFFF_FFFF : {tout_q[30:0], 1'b0};
        end
        tel_d = '0;
        ov_d = 1'b1; okind_d = KIND_RETX; oseq_d = 32'(rdata.start + 64'(iseq_q));
        opl_d = rdata.pl; osyn_d = rdata.syn; ofin_d = rdata.fin; olast_d = 1'b1;
        oinf_d = unack_q; oretx_d = retx_d;
      end
      ST_DONE: begin
        eslot_d = first_q;
        if (nres_q == '0) begin
          ov_d = 1'b1; okind_d = KIND_STATUS; oseq_d = 32'(next_q + 64'(iseq_q));
          opl_d = '0; osyn_d = 1'b0; ofin_d = 1'b0; olast_d = 1'b1;
          oinf_d = unack_q; oretx_d = retx_q;
        end
      end
      ST_EMIT_LD: begin
        ov_d = 1'b1; okind_d = KIND_NEW; oseq_d = 32'(rdata.start + 64'(iseq_q));
        opl_d = rdata.pl; osyn_d = rdata.syn; ofin_d = rdata.fin;
        olast_d = (k_inc == nres_q);
        oinf_d = unack_q; oretx_d = retx_q;
      end
      ST_OUT_WAIT: begin
        if (m_fire) begin
          ov_d = 1'b0;
          k_d = k_inc;
          eslot_d = eslot_inc;
        end
      end
      default: ;
    endcase

    // common push bookkeeping
    if (we) begin
      if (nres_q == '0) begin
        first_d = tail;
      end
      nres_d = nres_q + 1'b1;
      count_d = count_q + 1'b1;
      next_d = next_q + 64'(wdata.pl) + 64'(wdata.syn) + 64'(wdata.fin);
      unack_d = unack_q + 17'(wdata.pl) + 17'(wdata.syn) + 17'(wdata.fin);
      if (!ton_q) begin
        ton_d = 1'b1;
        tel_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      iseq_q <= InitSeqRst; ito_q <= InitTimeoutRst; mpay_q <= MaxPayloadRst;
      syn_sent_q <= 1'b0; fin_sent_q <= 1'b0;
      next_q <= '0; acked_q <= '0; win_q <= 16'd1; unack_q <= '0;
      ton_q <= 1'b0; tel_q <= '0; tout_q <= {16'd0, InitTimeoutRst}; retx_q <= '0;
      head_q <= '0; count_q <= '0;
      from_ack_q <= 1'b0; popped_q <= 1'b0;
      nres_q <= '0; k_q <= '0; first_q <= '0; eslot_q <= '0;
      ov_q <= 1'b0;
    end else begin
      state_q <= state_d;
      iseq_q <= iseq_d; ito_q <= ito_d; mpay_q <= mpay_d;
      syn_sent_q <= syn_sent_d; fin_sent_q <= fin_sent_d;
      next_q <= next_d; acked_q <= acked_d; win_q <= win_d; unack_q <= unack_d;
      ton_q <= ton_d; tel_q <= tel_d; tout_q <= tout_d; retx_q <= retx_d;
      head_q <= head_d; count_q <= count_d;
      from_ack_q <= from_ack_d; popped_q <= popped_d;
      nres_q <= nres_d; k_q <= k_d; first_q <= first_d; eslot_q <= eslot_d;
      ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wnd_q <= wnd_d; buf_q <= buf_d; ended_q <= ended_d;
    aabs_q <= aabs_d; room_q <= room_d;
    olast_q <= olast_d; osyn_q <= osyn_d; ofin_q <= ofin_d; okind_q <= okind_d;
    oseq_q <= oseq_d; opl_q <= opl_d; oinf_q <= oinf_d; oretx_q <= oretx_d;
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = ov_q;
  assign m_axis_tuser  = okind_q;
  assign m_axis_tlast  = olast_q;
  assign m_axis_tdata  = {1'b0, oretx_q, oinf_q, ofin_q, osyn_q, opl_q, oseq_q};

endmodule

/* sim/tswr_checker.sv */
// Checker for the TCP sender engine: predicts segment descriptors and compares transfers.
module tswr_checker
  import tswr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [87:0] s_axis_tdata,
  input  logic [1:0]  s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [71:0] m_axis_tdata,
  input  logic [1:0]  m_axis_tuser,
  input  logic        m_axis_tlast,
  output int          fail_cnt_o,
  output int          seg_left_o
);

  typedef struct {
    kind_e       kind;
    logic [31:0] seqno;
    logic [11:0] plen;
    logic        syn;
    logic        fin;
    logic        last;
    logic [16:0] inflight;
    logic [7:0]  retx;
  } seg_t;

  seg_t seg_q[$];
  seg_t burst_q[$];

  // configuration copy
  logic [31:0] iseq;
  logic [15:0] init_to;
  logic [11:0] max_pl;

  // connection state
  logic        syn_sent, fin_sent, timer_on;
  logic [63:0] next_abs, acked_abs;
  logic [15:0] wnd_seen;
  logic [16:0] unacked;
  logic [31:0] tmr_elapsed, rto;
  logic [7:0]  retx_run;
  logic [63:0] pend_start [QueueDepthDef];
  logic [13:0] pend_meta  [QueueDepthDef];
  int unsigned q_head, q_count;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("tswr_checker: mismatch %s got %h want %h at %0t", what, got, want, $time);
    fail_cnt_o++;
  endtask

  function automatic logic [31:0] wrap_seq(input logic [63:0] a);
    logic [63:0] s;
    s = a + {32'd0, iseq};
    return s[31:0];
  endfunction

  function automatic logic [16:0] meta_len(input logic [13:0] m);
    return {5'd0, m[11:0]} + 17'(m[12]) + 17'(m[13]);
  endfunction

  function automatic bit can_send();
    return burst_q.size() < MaxBurstDef && q_count < QueueDepthDef;
  endfunction

  task automatic add_seg(input kind_e k, input logic [63:0] a, input logic [11:0] pl,
                         input logic s, input logic f);
    seg_t r;
    r.kind = k; r.seqno = wrap_seq(a); r.plen = pl; r.syn = s; r.fin = f;
    r.last = 0; r.inflight = '0; r.retx = '0;
    burst_q.push_back(r);
  endtask

  task automatic send_seg(input logic [11:0] pl, input logic s, input logic f);
    int unsigned slot;
    logic [13:0] m;
    m = {f, s, pl};
    slot = (q_head + q_count) % QueueDepthDef;
    add_seg(KIND_NEW, next_abs, pl, s, f);
    pend_start[slot] = next_abs;
    pend_meta[slot]  = m;
    q_count++;
    next_abs = next_abs + 64'(meta_len(m));
    unacked  = unacked + meta_len(m);
    if (!timer_on) begin
      timer_on = 1;
      tmr_elapsed = '0;
    end
  endtask

  task automatic do_fill(input logic [15:0] buffered_in, input logic ended);
    longint win, room;
    int unsigned mp, pl, buffered;
    logic f;
    buffered = buffered_in;
    mp = (max_pl != 0) ? max_pl : 1;
    if (!syn_sent) begin
      if (!can_send()) return;
      syn_sent = 1;
      send_seg(12'd0, 1'b1, 1'b0);
      return;
    end
    // a SYN still outstanding blocks data
    if (q_count != 0 && pend_meta[q_head][12]) return;
    if (fin_sent) return;
    win  = (wnd_seen != 0) ? longint'(wnd_seen) : 1;
    room = win - longint'(next_abs - acked_abs);
    if (ended && buffered == 0) begin
      if (room > 0 && can_send()) begin
        fin_sent = 1;
        send_seg(12'd0, 1'b0, 1'b1);
      end
      return;
    end
    while (buffered > 0 && room >= 1 && can_send()) begin
      pl = mp;
      f  = 0;
      if (buffered < pl) pl = buffered;
      if (longint'(pl) > room) pl = int'(room);
      buffered -= pl;
      if (ended && buffered == 0 && room > longint'(pl)) begin
        f = 1;
        fin_sent = 1;
      end
      send_seg(pl[11:0], 1'b0, f);
      room -= longint'(pl) + f;
      if (f) break;
    end
  endtask

  task automatic do_ack(input logic [31:0] ackno, input logic [15:0] wnd,
                        input logic [15:0] buffered, input logic ended);
    logic [31:0] rel, d;
    logic [63:0] a, back;
    bit popped;
    popped = 0;
    rel = ackno - iseq;
    d   = rel - next_abs[31:0];
    if (d < 32'h8000_0000) a = next_abs + {32'd0, d};
    else begin
      back = 64'h1_0000_0000 - {32'd0, d};
      a = (next_abs >= back) ? next_abs - back : next_abs + {32'd0, d};
    end
    if (a > next_abs) return;
    wnd_seen = wnd;
    if (a <= acked_abs) return;
    acked_abs = a;
    while (q_count != 0) begin
      if (pend_start[q_head] + 64'(meta_len(pend_meta[q_head])) > a) break;
      unacked = unacked - meta_len(pend_meta[q_head]);
      q_head  = (q_head + 1) % QueueDepthDef;
      q_count--;
      popped = 1;
    end
    if (popped) do_fill(buffered, ended);
    retx_run = '0;
    rto = {16'd0, init_to};
    if (q_count == 0) timer_on = 0;
    else begin
      tmr_elapsed = '0;
      timer_on = 1;
    end
  endtask

  task automatic do_tick(input logic [15:0] ms);
    logic [32:0] sum;
    logic [13:0] m;
    if (!timer_on) return;
    sum = {1'b0, tmr_elapsed} + ms;
    tmr_elapsed = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    if (tmr_elapsed < rto || q_count == 0) return;
    m = pend_meta[q_head];
    add_seg(KIND_RETX, pend_start[q_head], m[11:0], m[12], m[13]);
    if (wnd_seen != 0 || m[12]) begin
      if (retx_run != 8'hFF) retx_run++;
      rto = (rto > 32'h7FFF_FFFF) ? 32'hFFFF_FFFF : rto << 1;
    end
    tmr_elapsed = '0;
  endtask

  task automatic predict(input op_e op, input logic [87:0] d);
    burst_q.delete();
    case (op)
      OP_FILL:  do_fill(d[79:64], d[80]);
      OP_ACK:   do_ack(d[31:0], d[47:32], d[79:64], d[80]);
      OP_TICK:  do_tick(d[63:48]);
      default:  add_seg(KIND_EMPTY, next_abs, 12'd0, 1'b0, 1'b0);
    endcase
    if (burst_q.size() == 0) add_seg(KIND_STATUS, next_abs, 12'd0, 1'b0, 1'b0);
    foreach (burst_q[k]) begin
      burst_q[k].last = (k == burst_q.size() - 1);
      burst_q[k].inflight = unacked;
      burst_q[k].retx = retx_run;
      seg_q.push_back(burst_q[k]);
    end
  endtask

  task automatic compare_out();
    seg_t w;
    if (seg_q.size() == 0) begin
      report("unexpected transfer seqno", m_axis_tdata[31:0], 32'd0);
      return;
    end
    w = seg_q.pop_front();
    if (m_axis_tuser !== w.kind) report("kind", 32'(m_axis_tuser), 32'(w.kind));
    if (m_axis_tdata[31:0] !== w.seqno) report("seqno", m_axis_tdata[31:0], w.seqno);
    if (m_axis_tdata[43:32] !== w.plen) report("payload_len", 32'(m_axis_tdata[43:32]), 32'(w.plen));
    if (m_axis_tdata[44] !== w.syn) report("syn", 32'(m_axis_tdata[44]), 32'(w.syn));
    if (m_axis_tdata[45] !== w.fin) report("fin", 32'(m_axis_tdata[45]), 32'(w.fin));
    if (m_axis_tlast !== w.last) report("last", 32'(m_axis_tlast), 32'(w.last));
    if (m_axis_tdata[62:46] !== w.inflight)
      report("in_flight", 32'(m_axis_tdata[62:46]), 32'(w.inflight));
    if (m_axis_tdata[70:63] !== w.retx) report("retx_count", 32'(m_axis_tdata[70:63]), 32'(w.retx));
  endtask

  initial begin
    fail_cnt_o = 0;
    seg_left_o = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iseq = InitSeqRst; init_to = InitTimeoutRst; max_pl = MaxPayloadRst;
      syn_sent = 0; fin_sent = 0; timer_on = 0;
      next_abs = '0; acked_abs = '0; wnd_seen = 16'd1; unacked = '0;
      tmr_elapsed = '0; rto = {16'd0, InitTimeoutRst}; retx_run = '0;
      q_head = 0; q_count = 0;
      seg_q.delete();
      seg_left_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgInitSeq:     iseq = cfg_data_i;
          CfgInitTimeout: begin
            init_to = cfg_data_i[15:0];
            rto = {16'd0, init_to};
          end
          CfgMaxPayload:  max_pl = cfg_data_i[11:0];
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) compare_out();
      if (s_axis_tvalid && s_axis_tready) predict(op_e'(s_axis_tuser), s_axis_tdata);
      seg_left_o = seg_q.size();
    end
  end

endmodule

/* sim/tb_top.sv */
// Testbench top: stimulus, receiver stalls and verdict for the TCP sender engine.
module tb_top;
  import tswr_pkg::*;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        cfg_we_i = 0;
  logic [1:0]  cfg_idx_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [87:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic [71:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;

  int fail_cnt, seg_left;
  int phase = 0;
  bit rx_hold = 0;
  bit no_idle = 0;
  int rx_gap = 0;
  logic [31:0] seg_ends[$];

  tcp_sender_window_retransmit u_top (.*);

  tswr_checker u_chk (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast,
    .fail_cnt_o(fail_cnt), .seg_left_o(seg_left)
  );

  always begin
    #4 clk_i = 1;
    #4 clk_i = 0;
  end

  function automatic int pick_gap();
    if (no_idle || $urandom_range(0, 9) < 6) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(20, 60);
    return $urandom_range(1, 3);
  endfunction

  // receiver side
  always @(posedge clk_i) begin
    if (rx_hold) m_axis_tready <= 0;
    else if (rx_gap > 0) begin
      rx_gap <= rx_gap - 1;
      m_axis_tready <= 0;
    end else begin
      rx_gap <= pick_gap();
      m_axis_tready <= 1;
    end
  end

  // remember segment ends so acks can hit real boundaries
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready && m_axis_tuser == KIND_NEW) begin
      seg_ends.push_back(m_axis_tdata[31:0] + m_axis_tdata[43:32] + m_axis_tdata[44]
                         + m_axis_tdata[45]);
      if (seg_ends.size() > 200) void'(seg_ends.pop_front());
    end
  end

  // long receiver hold-off while fills keep coming
  initial begin
    wait (phase == 2);
    repeat (50) @(posedge clk_i);
    rx_hold = 1;
    repeat (600) @(posedge clk_i);
    rx_hold = 0;
  end

  task automatic send_evt(input op_e op, input logic [31:0] ackno, input logic [15:0] wnd,
                          input logic [15:0] ms, input logic [15:0] buffered,
                          input logic ended);
    int gap;
    s_axis_tvalid <= 1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {7'd0, ended, buffered, ms, wnd, ackno};
    do @(posedge clk_i); while (!s_axis_tready);
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 0;
    @(posedge clk_i);
    while (seg_left != 0) @(posedge clk_i);
    // an input may still be in progress on a later result
    repeat (200) @(posedge clk_i);
  endtask

  task automatic write_cfg(input logic [31:0] seq, input logic [15:0] to,
                           input logic [11:0] mp);
    cfg_we_i <= 1; cfg_idx_i <= CfgInitSeq; cfg_data_i <= seq;
    @(posedge clk_i);
    cfg_idx_i <= CfgInitTimeout; cfg_data_i <= {16'd0, to};
    @(posedge clk_i);
    cfg_idx_i <= CfgMaxPayload; cfg_data_i <= {20'd0, mp};
    @(posedge clk_i);
    cfg_we_i <= 0;
  endtask

  function automatic logic [31:0] last_end();
    return (seg_ends.size() != 0) ? seg_ends[seg_ends.size() - 1] : 32'd0;
  endfunction

  function automatic logic [31:0] pick_ack();
    int sel, n;
    sel = $urandom_range(0, 9);
    n = seg_ends.size();
    if (n == 0 || sel == 0) return $urandom;
    if (sel < 7) return seg_ends[n - 1 - $urandom_range(0, (n > 4) ? 3 : n - 1)];
    if (sel == 7) return seg_ends[$urandom_range(0, n - 1)];
    if (sel == 8) return last_end() + 32'h8000_0000;
    return last_end() + 1;
  endfunction

  task automatic rand_evt(input bit with_end);
    int sel;
    logic [15:0] wnd, ms, buffered;
    logic ended;
    sel = $urandom_range(0, 9);
    case ($urandom_range(0, 9))
      0: wnd = 16'd0;
      1: wnd = 16'hFFFF;
      2, 3: wnd = $urandom;
      default: wnd = $urandom_range(1, 3000);
    endcase
    case ($urandom_range(0, 9))
      0: ms = 16'hFFFF;
      1: ms = 16'd0;
      2: ms = $urandom;
      default: ms = $urandom_range(0, 600);
    endcase
    case ($urandom_range(0, 9))
      0: buffered = 16'd0;
      1: buffered = 16'hFFFF;
      2: buffered = $urandom;
      default: buffered = $urandom_range(1, 3000);
    endcase
    ended = with_end ? ($urandom_range(0, 4) == 0) : 1'b0;
    if (sel < 4) send_evt(OP_FILL, $urandom, wnd, ms, buffered, ended);
    else if (sel < 7) send_evt(OP_ACK, pick_ack(), wnd, ms, buffered, ended);
    else if (sel < 9) send_evt(OP_TICK, $urandom, wnd, ms, buffered, ended);
    else send_evt(OP_EMPTY, $urandom, wnd, ms, buffered, ended);
  endtask

  initial begin
    logic [31:0] seq0;
    seq0 = 32'hFFFF_FFF0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: zero max payload, wrapping sequence numbers
    write_cfg(seq0, 16'd100, 12'd0);
    send_evt(OP_EMPTY, '0, '0, '0, '0, 0);
    send_evt(OP_TICK, '0, '0, 16'd500, '0, 0);
    send_evt(OP_FILL, '0, '0, '0, 16'd10, 0);          // lone SYN
    send_evt(OP_FILL, '0, '0, '0, 16'd10, 0);          // blocked behind SYN
    send_evt(OP_TICK, '0, '0, 16'd100, '0, 0);         // SYN resent
    send_evt(OP_ACK, seq0 + 32'd5, 16'd50, '0, 16'd10, 0); // beyond next, ignored
    send_evt(OP_ACK, seq0 + 32'd1, 16'd0, '0, 16'd10, 0);  // zero window counts as one
    send_evt(OP_FILL, '0, '0, '0, 16'd5, 0);
    send_evt(OP_TICK, '0, '0, 16'hFFFF, '0, 0);        // no backoff on zero window
    wait_idle();
    send_evt(OP_ACK, last_end(), 16'd100, '0, 16'hFFFF, 0); // burst limit
    send_evt(OP_ACK, seq0 + 32'd1, 16'd3, '0, '0, 0);  // old ack shrinks window
    send_evt(OP_FILL, '0, '0, '0, 16'd10, 0);          // negative room
    wait_idle();
    send_evt(OP_ACK, last_end() + 32'h8000_0000, 16'd10, '0, '0, 0);
    send_evt(OP_ACK, last_end(), 16'hFFFF, '0, 16'hFFFF, 0);
    send_evt(OP_FILL, '0, '0, '0, 16'hFFFF, 0);        // queue may fill here
    send_evt(OP_TICK, '0, '0, 16'd300, '0, 0);
    wait_idle();

    phase = 1;
    write_cfg($urandom, 16'd0, 12'd1);
    repeat (75) rand_evt(0);
    wait_idle();

    phase = 2;
    write_cfg(32'hFFFF_FFFF, 16'hFFFF, 12'd4095);
    repeat (80) rand_evt(0);
    wait_idle();

    phase = 3;
    no_idle = 1;
    write_cfg($urandom, 16'd300, 12'd7);
    repeat (40) rand_evt(0);
    wait_idle();
    no_idle = 0;
    repeat (40) rand_evt(0);
    wait_idle();

    // closing the stream: FIN with data, then an ended fill with an empty buffer
    phase = 4;
    write_cfg(32'd0, 16'd1000, 12'd1460);
    send_evt(OP_ACK, last_end(), 16'hFFFF, '0, '0, 0);
    send_evt(OP_FILL, '0, '0, '0, 16'd40, 1);
    send_evt(OP_FILL, '0, '0, '0, 16'd0, 1);
    repeat (70) rand_evt(1);
    wait_idle();

    if (fail_cnt == 0) $display("tb_top: PASS");
    else $display("tb_top: FAIL");
    $finish;
  end

  initial begin
    #100000000;
    $display("tb_top: FAIL");
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/tswr_pkg.sv
hw/rtl/tswr_queue.sv
hw/rtl/tcp_sender_window_retransmit.sv
sim/tswr_checker.sv
sim/tb_top.sv
